// ===== rtl/core/tfmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfmd_pkg
// Types, register map and constants shared by the three-frame motion detector.
// ----------------------------------------------------------------------------
package tfmd_pkg;

  localparam int DEF_MAX_WIDTH  = 640;
  localparam int DEF_MAX_HEIGHT = 480;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROI_X_START  = 3'd2;
  localparam logic [2:0] REG_ROI_X_STOP   = 3'd3;
  localparam logic [2:0] REG_ROI_Y_START  = 3'd4;
  localparam logic [2:0] REG_ROI_Y_STOP   = 3'd5;
  localparam logic [2:0] REG_CHANGES_THR  = 3'd6;
  localparam logic [2:0] REG_MAX_DEV      = 3'd7;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [7:0]  DIFF_LIMIT    = 8'd35;
  localparam logic [15:0] FULL_SCALE_SQ = 16'd65025;
  localparam logic [16:0] CHANGES_MAX   = 17'h1FFFF;
  localparam logic [18:0] TOTAL_MAX     = 19'h7FFFF;

  typedef struct packed {
    logic [7:0] first_channel;
    logic [7:0] second_channel;
    logic [7:0] third_channel;
  } in_data_t;

  typedef struct packed {
    logic        motion_detected;
    logic        deviation_ok;
    logic [16:0] changed_count;
    logic [18:0] moving_total;
  } out_data_t;

endpackage

// ===== rtl/core/tfmd_ram.sv =====
// ----------------------------------------------------------------------------
// tfmd_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/three_frame_motion_detector.sv =====
// ----------------------------------------------------------------------------
// three_frame_motion_detector
// Gray conversion, three-frame difference mask, 2x2 erosion and per-frame
// motion decision. Gray history and the previous mask row live in RAM.
// ----------------------------------------------------------------------------
//  channel  signals                              beat
//  in       in_valid / in_stall / in_data        one color pixel, raster order
//  out      out_valid / out_stall / out_data     one decision per frame end from frame 4 on
//  cfg      psel penable pwrite paddr pwdata ... one register write or read
//
//  A pixel is taken in S_IDLE, where the frame and row RAM read is issued;
//  S_RD then computes the mask and writes back. No pixel is taken while its
//  RAM access is open. At a decision frame end the deviation test runs on a
//  bit-serial multiplier: 4 products, each loaded in S_LOAD and shifted over
//  MW multiplier bits in S_MUL (MW = 19 at 640x480), while in_stall is high.
//  Reset is synchronous; RAMs need no clearing. The output register frees
//  the core while a result waits on out_stall.
// ----------------------------------------------------------------------------
module three_frame_motion_detector
  import tfmd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_data_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_data_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int DEP = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = $clog2(DEP);
  localparam int NW  = $clog2(DEP + 1);
  localparam int MW  = (NW > 16) ? NW : 16;
  localparam int PW  = 2 * NW + 16;
  localparam int XW  = (WW > 10) ? WW : 10;
  localparam int YW  = (HW > 9) ? HW : 9;
  localparam int KW  = (NW > 19) ? NW : 19;
  localparam int BW  = $clog2(MW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // ---------------- configuration ----------------
  logic [9:0]  fw_r, xs_r, xe_r;
  logic [8:0]  fh_r, ys_r, ye_r;
  logic [16:0] thr_r;
  logic [7:0]  dev_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= 10'd640;
      fh_r  <= 9'd480;
      xs_r  <= 10'd0;
      xe_r  <= 10'd640;
      ys_r  <= 9'd0;
      ye_r  <= 9'd480;
      thr_r <= 17'd20;
      dev_r <= 8'd50;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FRAME_WIDTH:  fw_r  <= pwdata[9:0];
        REG_FRAME_HEIGHT: fh_r  <= pwdata[8:0];
        REG_ROI_X_START:  xs_r  <= pwdata[9:0];
        REG_ROI_X_STOP:   xe_r  <= pwdata[9:0];
        REG_ROI_Y_START:  ys_r  <= pwdata[8:0];
        REG_ROI_Y_STOP:   ye_r  <= pwdata[8:0];
        REG_CHANGES_THR:  thr_r <= pwdata[16:0];
        REG_MAX_DEV:      dev_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FRAME_WIDTH:  prdata = CFG_DW'(fw_r);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(fh_r);
      REG_ROI_X_START:  prdata = CFG_DW'(xs_r);
      REG_ROI_X_STOP:   prdata = CFG_DW'(xe_r);
      REG_ROI_Y_START:  prdata = CFG_DW'(ys_r);
      REG_ROI_Y_STOP:   prdata = CFG_DW'(ye_r);
      REG_CHANGES_THR:  prdata = CFG_DW'(thr_r);
      REG_MAX_DEV:      prdata = CFG_DW'(dev_r);
      default:          prdata = '0;
    endcase
  end

  // bounded geometry
  logic [WW-1:0] w_b;
  logic [HW-1:0] h_b;
  logic [NW-1:0] n_pix;

  always_comb begin
    if (fw_r == 10'd0) w_b = WW'(1);
    else if (XW'(fw_r) > XW'(MAX_WIDTH)) w_b = WW'(MAX_WIDTH);
    else w_b = WW'(fw_r);
    if (fh_r == 9'd0) h_b = HW'(1);
    else if (YW'(fh_r) > YW'(MAX_HEIGHT)) h_b = HW'(MAX_HEIGHT);
    else h_b = HW'(fh_r);
  end

  assign n_pix = NW'(w_b) * NW'(h_b);

  // ---------------- control state ----------------
  logic [2:0]    state_r;
  logic [CW-1:0] pos_col_r, col_r, col_sat;
  logic [RW-1:0] pos_row_r, row_r, row_sat;
  logic [1:0]    frames_r;
  logic          left_r, above_left_r;
  logic [18:0]   total_r, total_nxt;
  logic [16:0]   sampled_r, sampled_nxt;
  logic [7:0]    c0_r, c1_r, c2_r;
  logic          in_fire, out_fire;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign col_sat = (WW'(pos_col_r) >= w_b) ? CW'(w_b - WW'(1)) : pos_col_r;
  assign row_sat = (HW'(pos_row_r) >= h_b) ? RW'(h_b - HW'(1)) : pos_row_r;

  // ---------------- memories ----------------
  logic [AW-1:0] fr_raddr, fr_waddr;
  logic [15:0]   fr_rdata, fr_wdata;
  logic          mk_rdata;
  logic          wr_en;

  assign fr_raddr = AW'(row_sat) * AW'(MAX_WIDTH) + AW'(col_sat);
  assign fr_waddr = AW'(row_r) * AW'(MAX_WIDTH) + AW'(col_r);
  assign wr_en    = (state_r == S_RD);

  tfmd_ram #(.WIDTH(16), .DEPTH(DEP)) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  logic raw;

  tfmd_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (col_r),
    .wdata (raw),
    .raddr (col_sat),
    .rdata (mk_rdata)
  );

  // ---------------- pixel datapath ----------------
  logic [22:0] gsum;
  logic [7:0]  gray, older, middle, d1, d2;
  logic        ero, on_x, on_y, last_col, last_row;

  assign gsum   = 23'd4899 * 23'(c0_r) + 23'd9617 * 23'(c1_r)
                + 23'd1868 * 23'(c2_r) + 23'd8192;
  assign gray   = gsum[21:14];
  assign older  = fr_rdata[15:8];
  assign middle = fr_rdata[7:0];
  assign d1     = (older > gray) ? older - gray : gray - older;
  assign d2     = (gray > middle) ? gray - middle : middle - gray;
  assign raw    = (d1 & d2) > DIFF_LIMIT;
  assign fr_wdata = {middle, gray};

  // out-of-frame neighbors count as set
  assign ero = raw && ((col_r == '0) || left_r)
                   && ((row_r == '0) || (mk_rdata && ((col_r == '0) || above_left_r)));

  assign on_x = (XW'(col_r) >= XW'(xs_r)) && (XW'(col_r) < XW'(xe_r))
             && (col_r[0] == xs_r[0]);
  assign on_y = (YW'(row_r) >= YW'(ys_r)) && (YW'(row_r) < YW'(ye_r))
             && (row_r[0] == ys_r[0]);

  assign last_col = (WW'(col_r) + WW'(1)) >= w_b;
  assign last_row = (HW'(row_r) + HW'(1)) >= h_b;

  always_comb begin
    total_nxt   = total_r;
    sampled_nxt = sampled_r;
    if (ero) begin
      if (total_r < TOTAL_MAX) total_nxt = total_r + 19'd1;
      if (on_x && on_y && (sampled_r < CHANGES_MAX)) sampled_nxt = sampled_r + 17'd1;
    end
  end

  // ---------------- deviation test: bit-serial multiplier ----------------
  logic [1:0]    step_r;
  logic [BW-1:0] bit_cnt_r;
  logic [PW-1:0] mcand_r, acc_r, acc_nxt, a_r, b_r;
  logic [MW-1:0] mplier_r;
  logic [NW-1:0] k_c;
  logic [15:0]   dev_sq;
  logic          dev_ok;
  logic [16:0]   cnt_out;

  assign k_c     = (KW'(total_r) > KW'(n_pix)) ? n_pix : NW'(total_r);
  assign dev_sq  = 16'(dev_r) * 16'(dev_r);
  assign acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign dev_ok  = b_r < a_r;
  assign cnt_out = dev_ok ? sampled_r : 17'd0;
  assign out_fire = (state_r == S_OUT) && !(out_valid && out_stall);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_col_r    <= '0;
      pos_row_r    <= '0;
      frames_r     <= 2'd0;
      left_r       <= 1'b0;
      above_left_r <= 1'b0;
      total_r      <= '0;
      sampled_r    <= '0;
      step_r       <= 2'd0;
      bit_cnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          total_r      <= total_nxt;
          sampled_r    <= sampled_nxt;
          left_r       <= raw;
          above_left_r <= mk_rdata;
          state_r      <= S_IDLE;
          if (!last_col) begin
            pos_col_r <= col_r + CW'(1);
            pos_row_r <= row_r;
          end else begin
            pos_col_r    <= '0;
            left_r       <= 1'b0;
            above_left_r <= 1'b0;
            if (!last_row) begin
              pos_row_r <= row_r + RW'(1);
            end else begin
              pos_row_r <= '0;
              if (frames_r != 2'd3) begin
                frames_r  <= frames_r + 2'd1;
                total_r   <= '0;
                sampled_r <= '0;
              end else begin
                step_r  <= 2'd0;
                state_r <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          bit_cnt_r <= '0;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          bit_cnt_r <= bit_cnt_r + BW'(1);
          if (bit_cnt_r == BW'(MW - 1)) begin
            step_r  <= step_r + 2'd1;
            state_r <= (step_r == 2'd3) ? S_OUT : S_LOAD;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            total_r   <= '0;
            sampled_r <= '0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers: channels, pixel position, multiplier operands
  always_ff @(posedge clk) begin
    if (in_fire) begin
      c0_r  <= in_data.first_channel;
      c1_r  <= in_data.second_channel;
      c2_r  <= in_data.third_channel;
      col_r <= col_sat;
      row_r <= row_sat;
    end
    if (state_r == S_LOAD) begin
      acc_r <= '0;
      case (step_r)
        2'd0: begin
          mcand_r  <= PW'(k_c);
          mplier_r <= MW'(n_pix - k_c);
        end
        2'd1: begin
          mcand_r  <= a_r;
          mplier_r <= MW'(FULL_SCALE_SQ);
        end
        2'd2: begin
          mcand_r  <= PW'(n_pix);
          mplier_r <= MW'(n_pix);
        end
        default: begin
          mcand_r  <= a_r;
          mplier_r <= MW'(dev_sq);
        end
      endcase
    end else if (state_r == S_MUL) begin
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      if (bit_cnt_r == BW'(MW - 1)) begin
        // k*(N-k) and N*N go to a_r, the scaled variance to b_r, dev^2*N^2 to a_r
        if (step_r == 2'd1) b_r <= acc_nxt;
        else a_r <= acc_nxt;
      end
    end
  end

  // ---------------- output register ----------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_data.motion_detected <= cnt_out >= thr_r;
      out_data.deviation_ok    <= dev_ok;
      out_data.changed_count   <= cnt_out;
      out_data.moving_total    <= total_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> (WW'(col_r) < w_b) && (HW'(row_r) < h_b))
    else $error("pixel position outside frame");

  a_sampled_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    KW'(sampled_r) <= KW'(total_r))
    else $error("sampled count exceeds mask total");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> bit_cnt_r < BW'(MW))
    else $error("multiplier ran past its length");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("decision not presented");

endmodule
